>>> design/ssmc_pkg.sv
package ssmc_pkg;

   localparam int NEEDLE_BYTES     = 16;
   localparam int LINE_WORDS       = 32;
   localparam int NEEDLE_REG_BYTES = 16;
   localparam int HIST_DEPTH       = NEEDLE_BYTES - 1;
   localparam int LEN_MAX          = (NEEDLE_REG_BYTES < NEEDLE_BYTES) ?
                                     NEEDLE_REG_BYTES : NEEDLE_BYTES;
   localparam int LEN_W            = $clog2(LEN_MAX + 1);
   localparam int HCNT_W           = $clog2(HIST_DEPTH + 1);
   localparam int WIN_IDX_W        = $clog2(NEEDLE_BYTES);
   localparam int POS_W            = 31;
   localparam int LINE_CNT_W       = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
   localparam int FILL_W           = $clog2(LINE_WORDS + 1);
   localparam int JOB_QUEUE_DEPTH  = 4;
   localparam int JQ_PTR_W         = $clog2(JOB_QUEUE_DEPTH);
   localparam int JQ_CNT_W         = $clog2(JOB_QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
   localparam logic [31:0]      FILL_WORD = 32'h7FFF_FFFF;

   typedef enum logic [0:0] {
      CSR_NEEDLE_LOW  = 1'b0,
      CSR_NEEDLE_HIGH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_word;
      logic               is_fill;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic              has_match;
      logic [31:0]       start;
      logic [FILL_W-1:0] fills;
   } job_type;

endpackage

>>> design/ssmc_front.sv
module ssmc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  ssmc_pkg::req_type      req_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  ssmc_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_data,
   input  logic                   job_full,
   output logic                   job_push,
   output ssmc_pkg::job_type      job_data
);
   import ssmc_pkg::*;

   logic [63:0]           needle_low_ff, needle_low_in;
   logic [63:0]           needle_high_ff, needle_high_in;
   logic [7:0]            hist_ff [HIST_DEPTH];
   logic [7:0]            hist_in [HIST_DEPTH];
   logic [HCNT_W-1:0]     hcnt_ff, hcnt_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [LINE_CNT_W-1:0] mcnt_ff, mcnt_in;

   logic [127:0]          needle_all;
   logic [7:0]            win [NEEDLE_BYTES];
   logic [LEN_W-1:0]      len;
   logic                  hit;
   logic                  accept;
   logic                  csr_wr;
   logic [LINE_CNT_W-1:0] mcnt_next;
   logic [FILL_W-1:0]     fills;

   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid && csr_ready;
   assign req_full   = job_full;
   assign accept     = req_push && !req_full;
   assign needle_all = {needle_high_ff, needle_low_ff};

   // Needle length runs to the first zero byte
   always_comb begin
      logic stop;
      stop = 1'b0;
      len  = '0;
      for (int k = 0; k < LEN_MAX; k++) begin
         if (!stop && needle_all[8*k +: 8] != 8'd0) begin
            len = LEN_W'(k + 1);
         end else begin
            stop = 1'b1;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < HIST_DEPTH; j++) begin
         win[j] = hist_ff[j];
      end
      win[NEEDLE_BYTES-1] = req_data.text_byte;
   end

   // Compare the tail of the window with the needle
   always_comb begin
      logic [WIN_IDX_W-1:0] idx;
      hit = (len != '0) && (({1'b0, hcnt_ff} + (HCNT_W+1)'(1)) >= (HCNT_W+1)'(len));
      for (int i = 0; i < LEN_MAX; i++) begin
         idx = WIN_IDX_W'(NEEDLE_BYTES - int'(len) + i);
         if (i < int'(len) && win[idx] != needle_all[8*i +: 8]) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      logic [FILL_W-1:0] m;
      if (hit) begin
         mcnt_next = (int'(mcnt_ff) + 1 == LINE_WORDS) ? '0 : mcnt_ff + LINE_CNT_W'(1);
      end else begin
         mcnt_next = mcnt_ff;
      end
      m = (LINE_WORDS > 1) ? FILL_W'(mcnt_next) : '0;
      if (req_data.chunk_end && m != '0) begin
         fills = FILL_W'(LINE_WORDS) - m;
      end else begin
         fills = '0;
      end
   end

   always_comb begin
      job_data.has_match = hit;
      job_data.start     = {1'b0, pos_ff} - 32'(len - LEN_W'(1));
      job_data.fills     = fills;
      job_push           = accept && (hit || fills != '0);
   end

   always_comb begin
      needle_low_in  = needle_low_ff;
      needle_high_in = needle_high_ff;
      hist_in        = hist_ff;
      hcnt_in        = hcnt_ff;
      pos_in         = pos_ff;
      mcnt_in        = mcnt_ff;
      if (accept) begin
         for (int j = 0; j < HIST_DEPTH; j++) begin
            hist_in[j] = win[j+1];
         end
         if (int'(hcnt_ff) < HIST_DEPTH) begin
            hcnt_in = hcnt_ff + HCNT_W'(1);
         end
         if (req_data.chunk_end) begin
            pos_in  = '0;
            mcnt_in = '0;
         end else begin
            mcnt_in = mcnt_next;
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
      if (csr_wr) begin
         hcnt_in = '0;
         unique case (csr_index)
            CSR_NEEDLE_LOW:  needle_low_in  = csr_data;
            CSR_NEEDLE_HIGH: needle_high_in = csr_data;
            default:         needle_low_in  = needle_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
      if (reset) begin
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         hcnt_ff        <= '0;
         pos_ff         <= '0;
         mcnt_ff        <= '0;
      end else begin
         needle_low_ff  <= needle_low_in;
         needle_high_ff <= needle_high_in;
         hcnt_ff        <= hcnt_in;
         pos_ff         <= pos_in;
         mcnt_ff        <= mcnt_in;
      end
   end

endmodule

>>> design/ssmc_job_queue.sv
module ssmc_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ssmc_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output ssmc_pkg::job_type head_data
);
   import ssmc_pkg::*;

   job_type               entry_ff [JOB_QUEUE_DEPTH];
   logic [JQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (int'(count_ff) == JOB_QUEUE_DEPTH);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == JOB_QUEUE_DEPTH - 1) ? '0 :
                     wr_ptr_ff + JQ_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == JOB_QUEUE_DEPTH - 1) ? '0 :
                     rd_ptr_ff + JQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + JQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - JQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/ssmc_back.sv
module ssmc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  ssmc_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ssmc_pkg::rsp_type rsp_data
);
   import ssmc_pkg::*;

   logic              busy_ff, busy_in;
   logic              match_ff, match_in;
   logic [31:0]       start_ff, start_in;
   logic [FILL_W-1:0] fills_ff, fills_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_load;
   logic              emit;
   logic              last_now;

   assign out_load = !out_valid_ff || rsp_pop;
   assign emit     = busy_ff && out_load;
   assign last_now = match_ff ? (fills_ff == '0) : (fills_ff == FILL_W'(1));
   assign job_pop  = job_valid && (!busy_ff || (emit && last_now));

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      busy_in      = busy_ff;
      match_in     = match_ff;
      start_in     = start_ff;
      fills_in     = fills_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_load) begin
         out_valid_in = emit;
      end
      // Match goes out first, then its fill words
      if (emit) begin
         out_in.last_of_run = last_now;
         if (match_ff) begin
            out_in.result_word = start_ff;
            out_in.is_fill     = 1'b0;
            match_in           = 1'b0;
         end else begin
            out_in.result_word = FILL_WORD;
            out_in.is_fill     = 1'b1;
            fills_in           = fills_ff - FILL_W'(1);
         end
         if (last_now) begin
            busy_in = 1'b0;
         end
      end
      if (job_pop) begin
         busy_in  = 1'b1;
         match_in = job_data.has_match;
         start_in = job_data.start;
         fills_in = job_data.fills;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      start_ff <= start_in;
      fills_ff <= fills_in;
      out_ff   <= out_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> design/streaming_substring_match_counter.sv
// A result passes the job queue and the result sequencer's job and output registers.
// Throughput: one byte per cycle in while the job queue has room, one result per cycle out
// while results are popped; a byte that ends a chunk may cause up to 32 results, drained at
// one per cycle by the result sequencer while a four-entry job queue lets the front keep
// taking bytes. Reset: synchronous, clears needle, history count, chunk position, match count and queues.
module streaming_substring_match_counter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  ssmc_pkg::req_type       req_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output ssmc_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  ssmc_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_data
);
   import ssmc_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   job_type q_in;
   job_type q_head;

   ssmc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job_full  (q_full),
      .job_push  (q_push),
      .job_data  (q_in)
   );

   ssmc_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_data (q_head)
   );

   ssmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job_data  (q_head),
      .job_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
